// File: design/jga_pkg.sv
// Shared constants for the J2 gravity pipeline: field widths, register
// indexes and reset values, and the stage timing of the datapath.
// No dependencies.
package jga_pkg;

    localparam int POS_W      = 48;
    localparam int ACC_W      = 48;
    localparam int MU_W       = 49;
    localparam int J2_W       = 32;
    localparam int RE_W       = 23;
    localparam int G0_W       = 31;
    localparam int CFG_DATA_W = 49;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MU = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_J2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_G0 = 3'd3;

    localparam logic [MU_W-1:0] MU_RST = 49'd398600441800000;
    localparam logic [J2_W-1:0] J2_RST = 32'd1190364275;
    localparam logic [RE_W-1:0] RE_RST = 23'd6378137;
    localparam logic [G0_W-1:0] G0_RST = 31'd164528285;

    // wide multiplier: 3 x 3 limbs of 32 bits
    localparam int MUL_W   = 96;
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = MUL_W / LIMB_W;
    localparam int MUL_LAT = 2;

    // restoring divider: 96-bit dividend and divisor, 80 quotient bits
    localparam int DIV_DW = 96;
    localparam int DIV_QW = 80;

    // square root of a 96-bit radicand
    localparam int SQ_NW = 96;
    localparam int SQ_RW = SQ_NW / 2;

    localparam int FM_W = 74;   // J2 factor magnitude, Q32
    localparam int M1_W = 74;   // mu/r^2 * unit vector

    // stage at which each value is registered, counted from acceptance
    localparam int T_SQ_IN = MUL_LAT + 1;
    localparam int T_ROOT  = T_SQ_IN + SQ_RW;
    localparam int T_QG    = T_SQ_IN + DIV_QW;
    localparam int T_U     = T_ROOT + DIV_QW;
    localparam int T_W     = T_U + MUL_LAT;
    localparam int T_D     = T_W + 1;
    localparam int T_C     = T_D + MUL_LAT;
    localparam int T_F     = T_C + 1;
    localparam int T_P     = T_F + MUL_LAT;
    localparam int T_M     = T_P + 1;
    localparam int T_SQ2   = T_M + MUL_LAT;
    localparam int T_MSQ   = T_SQ2 + 1;
    localparam int T_MAG   = T_MSQ + SQ_RW;
    localparam int LAT     = T_MAG + 1;

    localparam logic [FM_W-1:0]   Q32_ONE  = 74'h1_0000_0000;
    localparam logic [34:0]       KQ1      = 35'h1_0000_0000;
    localparam logic [34:0]       KQ3      = 35'h3_0000_0000;
    localparam logic [SQ_NW-1:0]  R2_ONE_M = 96'd65536;
    localparam logic [ACC_W-1:0]  POS_MAX  = 48'h7FFF_FFFF_FFFF;

endpackage

// File: design/jga_if.sv
// Valid/ready channel interfaces for position items and acceleration items.
// Depends on jga_pkg.
interface jga_pos_if import jga_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface jga_acc_if import jga_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
    logic        [ACC_W-1:0] acc_magnitude;
    logic                    saturated;

    modport source (output valid, output acc_x, output acc_y, output acc_z,
                    output acc_magnitude, output saturated, input ready);
    modport sink   (input valid, input acc_x, input acc_y, input acc_z,
                    input acc_magnitude, input saturated, output ready);
endinterface

// File: design/j2_gravity_acceleration.sv
// J2 zonal gravity pipeline: position item in, acceleration item out.
// One item per cycle while the output is not stalled. The 80-stage dividers (unit
// vector after the 48-stage root) and the 48-stage magnitude root set depth.
// A stalled output freezes the whole pipeline; ready is low during reset.
// Reset (synchronous) clears valid bits and loads default constants.
module j2_gravity_acceleration import jga_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jga_pos_if.sink               i_pos,
    jga_acc_if.source             o_acc,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [MU_W-1:0]   r_mu;
    logic [J2_W-1:0]   r_j2;
    logic [RE_W-1:0]   r_re;
    logic [G0_W-1:0]   r_g0;
    logic [2*RE_W-1:0] r_re_sq;

    logic [LAT:1] r_vld;
    logic         en;

    // input stage
    logic [POS_W-1:0] n_mag [3];
    logic [2:0]       n_pneg;
    logic [POS_W-1:0] pin [3];

    // delay lines
    logic [POS_W-1:0]  r_pmag [3][1:T_ROOT];
    logic [2:0]        r_pneg [1:T_P];
    logic              r_lt   [T_SQ_IN+1:T_MAG];
    logic [DIV_QW-1:0] r_qd   [T_QG+1:T_U];
    logic [DIV_QW-1:0] r_gd   [T_QG+1:T_U];
    logic [1:0]        r_dneg [T_D:T_C];
    logic [M1_W-1:0]   r_m1   [3][T_D:T_F];
    logic [1:0]        r_fneg [T_F:T_P];
    logic [ACC_W-1:0]  r_acc  [3][T_M:T_MAG];
    logic              r_sat  [T_M:T_MAG];

    logic [SQ_NW-1:0]  r_r2;
    logic [SQ_NW-1:0]  r_msq;
    logic [71:0]       r_t3;
    logic [34:0]       r_dmag [2];
    logic [FM_W-1:0]   r_fmag [2];
    logic [ACC_W-1:0]  r_cm   [3];

    logic [ACC_W-1:0]  r_ox, r_oy, r_oz, r_om;
    logic              r_os;

    logic [2*MUL_W-1:0] sq_p  [3];
    logic [2*MUL_W-1:0] gu_p  [3];
    logic [2*MUL_W-1:0] mf_p  [3];
    logic [2*MUL_W-1:0] cm_p  [3];
    logic [2*MUL_W-1:0] cp_p  [2];
    logic [2*MUL_W-1:0] uz_p;
    logic [2*MUL_W-1:0] jq_p;
    logic [DIV_QW-1:0]  u_quo [3];
    logic [DIV_QW-1:0]  q_quo;
    logic [DIV_QW-1:0]  g_quo;
    logic [SQ_RW-1:0]   root_r;
    logic [SQ_RW-1:0]   root_m;

    logic [71:0]       n_t3;
    logic [34:0]       n_dmag [2];
    logic [1:0]        n_dneg;
    logic [FM_W-1:0]   n_fmag [2];
    logic [1:0]        n_fneg;
    logic [ACC_W-1:0]  n_cm   [3];
    logic [ACC_W-1:0]  n_acc  [3];
    logic              n_sat;

    assign en          = !r_vld[LAT] || o_acc.ready;
    assign i_pos.ready = en && i_rst_n;
    assign o_acc.valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu  <= MU_RST;
            r_j2  <= J2_RST;
            r_re  <= RE_RST;
            r_g0  <= G0_RST;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MU:  r_mu <= i_cfg_data[MU_W-1:0];
                    CFG_J2:  r_j2 <= i_cfg_data[J2_W-1:0];
                    CFG_RE:  r_re <= i_cfg_data[RE_W-1:0];
                    CFG_G0:  r_g0 <= i_cfg_data[G0_W-1:0];
                    default: ;
                endcase
            end
            if (en) begin
                r_vld <= {r_vld[LAT-1:1], i_pos.valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_re_sq <= (2*RE_W)'(r_re) * (2*RE_W)'(r_re);
    end

    // magnitudes and signs; the most negative value keeps magnitude 2^47
    assign pin[0] = i_pos.pos_x;
    assign pin[1] = i_pos.pos_y;
    assign pin[2] = i_pos.pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_pneg[a] = pin[a][POS_W-1];
            n_mag[a]  = pin[a][POS_W-1] ? (~pin[a] + POS_W'(1)) : pin[a];
        end
    end

    // r^2
    for (genvar a = 0; a < 3; a++) begin : g_sq
        jga_mul u_sq (
            .i_clk (i_clk), .i_en (en),
            .i_a (MUL_W'(n_mag[a])), .i_b (MUL_W'(n_mag[a])),
            .o_p (sq_p[a])
        );
    end

    jga_sqrt u_root (
        .i_clk (i_clk), .i_en (en), .i_rad (r_r2), .o_root (root_r)
    );

    // (Re/r)^2 and mu/r^2
    jga_div u_div_q (
        .i_clk (i_clk), .i_en (en),
        .i_num (DIV_DW'({r_re_sq, 48'b0})), .i_den (r_r2), .o_quo (q_quo)
    );

    jga_div u_div_g (
        .i_clk (i_clk), .i_en (en),
        .i_num (DIV_DW'({r_mu, 40'b0})), .i_den (r_r2), .o_quo (g_quo)
    );

    // unit vector, Q32
    for (genvar a = 0; a < 3; a++) begin : g_unit
        jga_div u_div_u (
            .i_clk (i_clk), .i_en (en),
            .i_num (DIV_DW'({r_pmag[a][T_ROOT], 32'b0})),
            .i_den (DIV_DW'(root_r)), .o_quo (u_quo[a])
        );

        jga_mul u_gu (
            .i_clk (i_clk), .i_en (en),
            .i_a (MUL_W'(r_gd[T_U])), .i_b (MUL_W'(u_quo[a])),
            .o_p (gu_p[a])
        );
    end

    jga_mul u_uz (
        .i_clk (i_clk), .i_en (en),
        .i_a (MUL_W'(u_quo[2])), .i_b (MUL_W'(u_quo[2])), .o_p (uz_p)
    );

    jga_mul u_jq (
        .i_clk (i_clk), .i_en (en),
        .i_a (MUL_W'(r_j2)), .i_b (MUL_W'(r_qd[T_U])), .o_p (jq_p)
    );

    // D_k = 5*(z/r)^2 - k, kept as sign and magnitude
    always_comb begin
        logic [32:0] w_val;
        logic [69:0] t_val;
        logic [34:0] five_w;
        logic [34:0] kq;
        w_val  = uz_p[64:32];
        t_val  = jq_p[109:40];
        five_w = {w_val, 2'b00} + 35'(w_val);
        n_t3   = 72'({t_val, 1'b0}) + 72'(t_val);
        for (int k = 0; k < 2; k++) begin
            kq = (k == 0) ? KQ1 : KQ3;
            if (five_w >= kq) begin
                n_dneg[k] = 1'b0;
                n_dmag[k] = five_w - kq;
            end else begin
                n_dneg[k] = 1'b1;
                n_dmag[k] = kq - five_w;
            end
        end
    end

    for (genvar k = 0; k < 2; k++) begin : g_cf
        jga_mul u_cp (
            .i_clk (i_clk), .i_en (en),
            .i_a (MUL_W'(r_t3)), .i_b (MUL_W'(r_dmag[k])), .o_p (cp_p[k])
        );
    end

    // F_k = 1 - sign(D_k) * c_k
    always_comb begin
        logic [FM_W-1:0] c_val;
        for (int k = 0; k < 2; k++) begin
            c_val = FM_W'(cp_p[k][105:33]);
            if (r_dneg[T_C][k]) begin
                n_fmag[k] = c_val + Q32_ONE;
                n_fneg[k] = 1'b0;
            end else if (c_val <= Q32_ONE) begin
                n_fmag[k] = Q32_ONE - c_val;
                n_fneg[k] = 1'b0;
            end else begin
                n_fmag[k] = c_val - Q32_ONE;
                n_fneg[k] = 1'b1;
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_mf
        jga_mul u_mf (
            .i_clk (i_clk), .i_en (en),
            .i_a (MUL_W'(r_m1[a][T_F])), .i_b (MUL_W'(r_fmag[(a == 2) ? 1 : 0])),
            .o_p (mf_p[a])
        );

        jga_mul u_cm (
            .i_clk (i_clk), .i_en (en),
            .i_a (MUL_W'(r_cm[a])), .i_b (MUL_W'(r_cm[a])), .o_p (cm_p[a])
        );
    end

    // final scale, sign and clipping
    always_comb begin
        logic             neg;
        logic [ACC_W-1:0] limit;
        logic             over;
        logic [ACC_W-1:0] m;
        n_sat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            neg   = r_pneg[T_P][a] == r_fneg[T_P][(a == 2) ? 1 : 0];
            limit = POS_MAX + ACC_W'(neg);
            over  = (|mf_p[a][2*MUL_W-1:80]) || (mf_p[a][79:32] > limit);
            m     = over ? limit : mf_p[a][79:32];
            n_cm[a]  = m;
            n_acc[a] = neg ? (ACC_W'(0) - m) : m;
            n_sat    = n_sat || over;
        end
    end

    jga_sqrt u_mag (
        .i_clk (i_clk), .i_en (en), .i_rad (r_msq), .o_root (root_m)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_pmag[a][1] <= n_mag[a];
                for (int s = 2; s <= T_ROOT; s++) r_pmag[a][s] <= r_pmag[a][s-1];
                r_m1[a][T_D] <= gu_p[a][105:32];
                for (int s = T_D + 1; s <= T_F; s++) r_m1[a][s] <= r_m1[a][s-1];
                r_cm[a] <= n_cm[a];
                r_acc[a][T_M] <= n_acc[a];
                for (int s = T_M + 1; s <= T_MAG; s++) r_acc[a][s] <= r_acc[a][s-1];
            end
            r_pneg[1] <= n_pneg;
            for (int s = 2; s <= T_P; s++) r_pneg[s] <= r_pneg[s-1];

            r_r2 <= sq_p[0][SQ_NW-1:0] + sq_p[1][SQ_NW-1:0] + sq_p[2][SQ_NW-1:0];
            r_lt[T_SQ_IN+1] <= r_r2 < R2_ONE_M;
            for (int s = T_SQ_IN + 2; s <= T_MAG; s++) r_lt[s] <= r_lt[s-1];

            r_qd[T_QG+1] <= q_quo;
            r_gd[T_QG+1] <= g_quo;
            for (int s = T_QG + 2; s <= T_U; s++) begin
                r_qd[s] <= r_qd[s-1];
                r_gd[s] <= r_gd[s-1];
            end

            r_t3 <= n_t3;
            for (int k = 0; k < 2; k++) begin
                r_dmag[k] <= n_dmag[k];
                r_fmag[k] <= n_fmag[k];
            end
            r_dneg[T_D] <= n_dneg;
            for (int s = T_D + 1; s <= T_C; s++) r_dneg[s] <= r_dneg[s-1];
            r_fneg[T_F] <= n_fneg;
            for (int s = T_F + 1; s <= T_P; s++) r_fneg[s] <= r_fneg[s-1];

            r_sat[T_M] <= n_sat;
            for (int s = T_M + 1; s <= T_MAG; s++) r_sat[s] <= r_sat[s-1];

            r_msq <= cm_p[0][SQ_NW-1:0] + cm_p[1][SQ_NW-1:0] + cm_p[2][SQ_NW-1:0];

            // inside one metre the result is straight down at surface gravity
            if (r_lt[T_MAG]) begin
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= ACC_W'(0) - ACC_W'(r_g0);
                r_om <= ACC_W'(r_g0);
                r_os <= 1'b0;
            end else begin
                r_ox <= r_acc[0][T_MAG];
                r_oy <= r_acc[1][T_MAG];
                r_oz <= r_acc[2][T_MAG];
                r_om <= ACC_W'(root_m);
                r_os <= r_sat[T_MAG];
            end
        end
    end

    assign o_acc.acc_x         = r_ox;
    assign o_acc.acc_y         = r_oy;
    assign o_acc.acc_z         = r_oz;
    assign o_acc.acc_magnitude = r_om;
    assign o_acc.saturated     = r_os;

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT] && !o_acc.ready) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pos.valid && i_pos.ready) |=> r_vld[1])
        else $error("accepted item lost at pipeline entry");

    a_sat_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_acc.valid && o_acc.saturated) |-> (o_acc.acc_magnitude >= POS_MAX))
        else $error("saturated item with small magnitude");

endmodule

// File: design/jga_mul.sv
// Pipelined 96 x 96 unsigned multiplier: 32-bit limb products, then the sum.
// Depends on jga_pkg.
module jga_mul import jga_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic [2*MUL_W-1:0] o_p
);

    logic [2*LIMB_W-1:0] r_pp [LIMBS*LIMBS];
    logic [2*MUL_W-1:0]  n_p;
    logic [2*MUL_W-1:0]  r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LIMBS; i++) begin
                for (int j = 0; j < LIMBS; j++) begin
                    r_pp[i*LIMBS+j] <= (2*LIMB_W)'(i_a[i*LIMB_W +: LIMB_W])
                                     * (2*LIMB_W)'(i_b[j*LIMB_W +: LIMB_W]);
                end
            end
            r_p <= n_p;
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
                n_p = n_p + ((2*MUL_W)'(r_pp[i*LIMBS+j]) << (LIMB_W*(i+j)));
            end
        end
    end

    assign o_p = r_p;

endmodule

// File: design/jga_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Dividend must be below divisor * 2^DIV_QW. Depends on jga_pkg.
module jga_div import jga_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_DW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quo
);

    logic [DIV_DW-1:0] r_rem [DIV_QW];
    logic [DIV_QW-1:0] r_nq  [DIV_QW];
    logic [DIV_DW-1:0] r_den [DIV_QW];
    logic [DIV_DW-1:0] n_rem [DIV_QW];
    logic [DIV_QW-1:0] n_nq  [DIV_QW];
    logic [DIV_DW-1:0] n_den [DIV_QW];

    always_comb begin
        logic [DIV_DW-1:0] v_rem;
        logic [DIV_QW-1:0] v_nq;
        logic [DIV_DW-1:0] v_den;
        logic [DIV_DW:0]   v_t;
        logic              v_ge;
        for (int k = 0; k < DIV_QW; k++) begin
            if (k == 0) begin
                v_rem = i_num >> DIV_QW;
                v_nq  = i_num[DIV_QW-1:0];
                v_den = i_den;
            end else begin
                v_rem = r_rem[k-1];
                v_nq  = r_nq[k-1];
                v_den = r_den[k-1];
            end
            // nq holds the dividend bits still to come, quotient bits enter below
            v_t  = {v_rem, v_nq[DIV_QW-1]};
            v_ge = v_t >= {1'b0, v_den};
            n_rem[k] = v_ge ? DIV_DW'(v_t - {1'b0, v_den}) : v_t[DIV_DW-1:0];
            n_nq[k]  = {v_nq[DIV_QW-2:0], v_ge};
            n_den[k] = v_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_nq[DIV_QW-1];

endmodule

// File: design/jga_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on jga_pkg.
module jga_sqrt import jga_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SQ_NW-1:0] i_rad,
    output logic [SQ_RW-1:0] o_root
);

    logic [SQ_RW+1:0] r_rem  [SQ_RW];
    logic [SQ_RW-1:0] r_root [SQ_RW];
    logic [SQ_NW-1:0] r_rad  [SQ_RW];
    logic [SQ_RW+1:0] n_rem  [SQ_RW];
    logic [SQ_RW-1:0] n_root [SQ_RW];
    logic [SQ_NW-1:0] n_rad  [SQ_RW];

    always_comb begin
        logic [SQ_RW+1:0] v_rem;
        logic [SQ_RW-1:0] v_root;
        logic [SQ_NW-1:0] v_rad;
        logic [SQ_RW+3:0] v_t;
        logic [SQ_RW+1:0] v_trial;
        logic             v_ge;
        for (int k = 0; k < SQ_RW; k++) begin
            if (k == 0) begin
                v_rem  = '0;
                v_root = '0;
                v_rad  = i_rad;
            end else begin
                v_rem  = r_rem[k-1];
                v_root = r_root[k-1];
                v_rad  = r_rad[k-1];
            end
            v_t     = {v_rem, v_rad[SQ_NW-1:SQ_NW-2]};
            v_trial = {v_root, 2'b01};
            v_ge    = v_t >= (SQ_RW+4)'(v_trial);
            n_rem[k]  = v_ge ? (SQ_RW+2)'(v_t - (SQ_RW+4)'(v_trial))
                             : v_t[SQ_RW+1:0];
            n_root[k] = {v_root[SQ_RW-2:0], v_ge};
            n_rad[k]  = v_rad << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[SQ_RW-1];

endmodule

// File: bench/j2_gravity_acceleration_test.sv
// Testbench for the J2 gravity pipeline: directed and random position items,
// random stalls on both channels, results checked against an in-bench predictor or table values.
// Depends on jga_pkg, jga_if and j2_gravity_acceleration.
module j2_gravity_acceleration_test;
    import jga_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int                   WDOG_LIMIT = 6000;
    localparam logic signed [47:0]   P_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0]   P_MIN = 48'sh8000_0000_0000;
    localparam logic signed [47:0]   EQ_R  = 48'sd1632803072;   // equator, 1/256 m
    localparam logic signed [47:0]   PO_R  = 48'sd1627328512;   // pole
    localparam logic signed [47:0]   LEO_C = 48'sd1005054000;   // 6800 km orbit, per axis
    localparam logic signed [47:0]   GEO_R = 48'sd10793984000;

    typedef struct packed {
        logic signed [47:0] x, y, z;
    } t_pos;

    typedef struct packed {
        logic signed [47:0] x, y, z;
        logic        [47:0] mag;
        logic               sat;
    } t_acc;

    typedef struct packed {
        t_pos p;
        logic has;
        t_acc e;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    jga_pos_if pos_ch ();
    jga_acc_if acc_ch ();

    j2_gravity_acceleration dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pos(pos_ch), .o_acc(acc_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor copy of the constants
    logic [MU_W-1:0] mu_reg = MU_RST;
    logic [J2_W-1:0] j2_reg = J2_RST;
    logic [RE_W-1:0] re_reg = RE_RST;
    logic [G0_W-1:0] g0_reg = G0_RST;

    t_acc accel_q[$];
    logic typed_has_q[$];
    t_acc typed_val_q[$];
    int   errors = 0;
    int   sent = 0;
    int   tx_idle_pct = 27;
    int   rx_idle_pct = 58;
    int   quiet_cycles = 0;

    function automatic logic [255:0] isqrt(logic [255:0] n);
        logic [255:0] res, bitv;
        res = '0;
        bitv = 256'd1 << 254;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int bit_len(logic [255:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 256; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    // returns factor sign; magnitude Q32 in fmag
    function automatic logic j2_factor(logic [63:0] w, logic [63:0] k, logic [255:0] t,
                                       output logic [255:0] fmag);
        logic [63:0] five_w, kq, dmag;
        logic dneg;
        logic [255:0] c, one;
        five_w = 5 * w;
        kq = k << 32;
        one = 256'h1_0000_0000;
        dneg = five_w < kq;
        dmag = dneg ? kq - five_w : five_w - kq;
        c = ((t * 3 * dmag) & {128{1'b1}}) >> 33;
        if (dneg) begin
            fmag = one + c;
            return 1'b0;
        end
        if (c <= one) begin
            fmag = one - c;
            return 1'b0;
        end
        fmag = c - one;
        return 1'b1;
    endfunction

    function automatic t_acc gravity_predict(t_pos p);
        logic [47:0]  comp[3], neg48, limit;
        logic [255:0] mg[3], r2, r, q, t, g, m1, m, msq, fm[2];
        logic [63:0]  u[3], w;
        logic         pn[3], fn[2], neg, over, sat;
        logic [47:0]  outv[3];
        t_acc a;
        comp[0] = p.x; comp[1] = p.y; comp[2] = p.z;
        r2 = '0;
        for (int i = 0; i < 3; i++) begin
            pn[i] = comp[i][47];
            neg48 = -comp[i];
            mg[i] = 256'(pn[i] ? neg48 : comp[i]);
            r2 = r2 + mg[i] * mg[i];
        end
        if (r2 < 65536) begin
            a.x = '0; a.y = '0;
            a.z = -{17'd0, g0_reg};
            a.mag = 48'(g0_reg);
            a.sat = 1'b0;
            return a;
        end
        r = isqrt(r2);
        for (int i = 0; i < 3; i++) u[i] = 64'((mg[i] << 32) / r);
        w = 64'(({192'd0, u[2]} * u[2]) >> 32);
        q = ({233'd0, re_reg} * re_reg << 48) / r2;
        t = ((j2_reg * q) & {128{1'b1}}) >> 40;
        fn[0] = j2_factor(w, 64'd1, t, fm[0]);
        fn[1] = j2_factor(w, 64'd3, t, fm[1]);
        g = ({207'd0, mu_reg} << 40) / r2;
        sat = 1'b0;
        msq = '0;
        for (int i = 0; i < 3; i++) begin
            int f;
            f = (i == 2) ? 1 : 0;
            neg = (pn[i] == fn[f]);
            limit = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            m1 = ((g * u[i]) & {128{1'b1}}) >> 32;
            over = 1'b0;
            if (bit_len(m1) + bit_len(fm[f]) > 128) begin
                over = 1'b1;
            end else begin
                m = (m1 * fm[f]) >> 32;
                if (m > limit) over = 1'b1;
            end
            if (over) begin
                m = 256'(limit);
                sat = 1'b1;
            end
            outv[i] = neg ? -m[47:0] : m[47:0];
            msq = msq + m[47:0] * m[47:0];
        end
        a.x = outv[0]; a.y = outv[1]; a.z = outv[2];
        a.mag = 48'(isqrt(msq));
        a.sat = sat;
        return a;
    endfunction

    // input side: record the expectation of each accepted position item
    always @(posedge i_clk) begin
        logic has;
        t_acc tv;
        if (pos_ch.valid && pos_ch.ready) begin
            has = typed_has_q.pop_front();
            tv = typed_val_q.pop_front();
            accel_q.push_back(has ? tv : gravity_predict({pos_ch.pos_x, pos_ch.pos_y,
                                                          pos_ch.pos_z}));
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_acc e;
        if (i_rst_n && acc_ch.valid && acc_ch.ready) begin
            if (accel_q.size() == 0) begin
                $error("acceleration item with no expectation pending");
                errors++;
            end else begin
                e = accel_q.pop_front();
                if (acc_ch.acc_x !== e.x) begin
                    $error("acc_x expected %0d got %0d", e.x, acc_ch.acc_x); errors++;
                end
                if (acc_ch.acc_y !== e.y) begin
                    $error("acc_y expected %0d got %0d", e.y, acc_ch.acc_y); errors++;
                end
                if (acc_ch.acc_z !== e.z) begin
                    $error("acc_z expected %0d got %0d", e.z, acc_ch.acc_z); errors++;
                end
                if (acc_ch.acc_magnitude !== e.mag) begin
                    $error("acc_magnitude expected %0d got %0d", e.mag,
                           acc_ch.acc_magnitude);
                    errors++;
                end
                if (acc_ch.saturated !== e.sat) begin
                    $error("saturated expected %0b got %0b", e.sat, acc_ch.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) acc_ch.ready <= 1'b0;
        else acc_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((pos_ch.valid && pos_ch.ready) || (acc_ch.valid && acc_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("FAIL j2_gravity_acceleration");
            $finish;
        end
    end

    // write enable drops for one cycle between writes
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MU: mu_reg = data[MU_W-1:0];
            CFG_J2: j2_reg = data[J2_W-1:0];
            CFG_RE: re_reg = data[RE_W-1:0];
            CFG_G0: g0_reg = data[G0_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_pos(t_pos p, logic has, t_acc e);
        if (sent < 150) begin
            tx_idle_pct = 27; rx_idle_pct = 58;
        end else if (sent < 300) begin
            tx_idle_pct = 58; rx_idle_pct = 27;
        end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            pos_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        typed_has_q.push_back(has);
        typed_val_q.push_back(e);
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= p.x;
        pos_ch.pos_y <= p.y;
        pos_ch.pos_z <= p.z;
        do @(posedge i_clk); while (!pos_ch.ready);
        sent++;
    endtask

    task automatic drain();
        pos_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (accel_q.size() != 0 || typed_has_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    function automatic logic signed [47:0] rand_axis(int kind);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (kind)
            0, 1: return v[47:0];
            2, 3, 4, 5, 6: v = v >> (31 + $urandom_range(0, 2));
            7: v = v % 600;
            8: v = v % 150;
            default: v = (v >> 30) & {64{$urandom_range(0, 2) == 0}};
        endcase
        return $urandom_range(1) ? -v[47:0] : v[47:0];
    endfunction

    task automatic random_items(int n);
        t_pos p;
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            p.x = rand_axis(kind);
            p.y = rand_axis(kind);
            p.z = rand_axis(kind);
            send_pos(p, 1'b0, '0);
        end
    endtask

    t_acc near_origin;
    t_dir_row dir_tab[$];

    initial begin
        near_origin = '{x: 48'sd0, y: 48'sd0, z: -48'sd164528285,
                        mag: 48'd164528285, sat: 1'b0};
        dir_tab = '{
            '{p: '{48'sd0, 48'sd0, 48'sd0}, has: 1'b1, e: near_origin},
            '{p: '{48'sd255, 48'sd0, 48'sd0}, has: 1'b1, e: near_origin},
            '{p: '{48'sd0, -48'sd255, 48'sd0}, has: 1'b1, e: near_origin},
            '{p: '{-48'sd146, -48'sd146, -48'sd146}, has: 1'b1, e: near_origin},
            '{p: '{48'sd256, 48'sd0, 48'sd0}, has: 1'b0, e: '0},
            '{p: '{48'sd0, 48'sd0, 48'sd256}, has: 1'b0, e: '0},
            '{p: '{48'sd0, 48'sd0, -48'sd256}, has: 1'b0, e: '0},
            '{p: '{48'sd0, 48'sd300, -48'sd300}, has: 1'b0, e: '0},
            '{p: '{EQ_R, 48'sd0, 48'sd0}, has: 1'b0, e: '0},
            '{p: '{48'sd0, -EQ_R, 48'sd0}, has: 1'b0, e: '0},
            '{p: '{48'sd0, 48'sd0, PO_R}, has: 1'b0, e: '0},
            '{p: '{48'sd0, 48'sd0, -PO_R}, has: 1'b0, e: '0},
            '{p: '{LEO_C, -LEO_C, LEO_C}, has: 1'b0, e: '0},
            '{p: '{GEO_R, 48'sd0, 48'sd0}, has: 1'b0, e: '0},
            '{p: '{P_MAX, P_MAX, P_MAX}, has: 1'b0, e: '0},
            '{p: '{P_MIN, P_MIN, P_MIN}, has: 1'b0, e: '0},
            '{p: '{P_MAX, 48'sd0, 48'sd0}, has: 1'b0, e: '0},
            '{p: '{P_MIN, 48'sd0, 48'sd0}, has: 1'b0, e: '0},
            '{p: '{48'sd0, 48'sd0, P_MIN}, has: 1'b0, e: '0},
            '{p: '{-48'sd1, -48'sd1, -48'sd65536}, has: 1'b0, e: '0}
        };
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0;
        pos_ch.pos_y = '0;
        pos_ch.pos_z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default constants
        foreach (dir_tab[i]) send_pos(dir_tab[i].p, dir_tab[i].has, dir_tab[i].e);
        random_items(110);
        drain();

        // every constant at its top; the unused index must be ignored
        cfg_write(CFG_MU, {MU_W{1'b1}});
        cfg_write(CFG_J2, {CFG_DATA_W{1'b1}});
        cfg_write(CFG_RE, {CFG_DATA_W{1'b1}});
        cfg_write(CFG_G0, {CFG_DATA_W{1'b1}});
        cfg_write(CFG_UNUSED, 49'h1_2345_6789_ABCD);
        foreach (dir_tab[i]) if (!dir_tab[i].has) send_pos(dir_tab[i].p, 1'b0, '0);
        random_items(95);
        drain();

        cfg_write(CFG_MU, '0);
        cfg_write(CFG_J2, '0);
        cfg_write(CFG_RE, '0);
        cfg_write(CFG_G0, '0);
        random_items(60);
        drain();

        cfg_write(CFG_MU, CFG_DATA_W'({$urandom, $urandom}));
        cfg_write(CFG_J2, CFG_DATA_W'({$urandom, $urandom}));
        cfg_write(CFG_RE, CFG_DATA_W'($urandom));
        cfg_write(CFG_G0, CFG_DATA_W'($urandom));
        random_items(80);
        drain();

        cfg_write(CFG_MU, MU_RST);
        cfg_write(CFG_J2, CFG_DATA_W'(J2_RST));
        cfg_write(CFG_RE, CFG_DATA_W'(RE_RST));
        cfg_write(CFG_G0, CFG_DATA_W'(G0_RST));
        random_items(80);
        drain();

        if (errors == 0) $display("PASS j2_gravity_acceleration");
        else $display("FAIL j2_gravity_acceleration");
        $finish;
    end
endmodule
